@@ rtl/tbpf_pkg.sv @@
// tbpf_pkg: types, codes and default sizes for the three-band priority fifo
// used by every module of the block but tbpf_ram; depends on nothing else
`timescale 1ns / 1ps

package tbpf_pkg;

   // default sizes, taken as defaults by the top level parameters
   localparam int BAND_DEPTH_DEF  = 1024;
   localparam int NUM_BANDS_DEF   = 3;
   localparam int PRIO_LEVELS_DEF = 16;
   localparam int HANDLE_BITS_DEF = 16;

   // fixed field widths
   localparam int KIND_W      = 2;
   localparam int PRIO_W      = 4;
   localparam int STATUS_W    = 3;
   localparam int BAND_USED_W = 2;
   localparam int COUNT_W     = 11;
   localparam int MAP_W       = 32;
   localparam int MAP_ENTRY_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   // register reset values
   localparam logic [MAP_W-1:0]   PRIORITY_MAP_RESET = 32'h5555_09A9;
   localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET  = 11'd1000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIORITY_MAP = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_LIMIT  = 1'b1;

   // operation codes; the unused code behaves as a flush
   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ENQUEUED = 3'd0,
      STATUS_DROPPED  = 3'd1,
      STATUS_DEQUEUED = 3'd2,
      STATUS_EMPTY    = 3'd3,
      STATUS_FLUSHED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PEEK,
      ST_LOAD
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic execute;
      logic peek;
      logic publish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

@@ rtl/tbpf_ram.sv @@
// tbpf_ram: generic single-port ram with registered read
// standalone, no package needed
`timescale 1ns / 1ps

module tbpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // storage and registered read port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ rtl/tbpf_ctrl.sv @@
// tbpf_ctrl: sequencer for one queue operation at a time
// uses tbpf_pkg for the state and command types
`timescale 1ns / 1ps

module tbpf_ctrl
   import tbpf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type dp_status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_PEEK;
         end
         ST_PEEK: begin
            cmd.peek = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (dp_status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/tbpf_datapath.sv @@
// tbpf_datapath: band pointers, counts, config registers, band memory and result register
// uses tbpf_pkg and instantiates tbpf_ram
`timescale 1ns / 1ps

module tbpf_datapath
   import tbpf_pkg::*;
#(
   parameter int BAND_DEPTH  = BAND_DEPTH_DEF,
   parameter int NUM_BANDS   = NUM_BANDS_DEF,
   parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output ctrl_status_type        dp_status,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [PRIO_W-1:0]      req_priority_req,
   input  logic [HANDLE_BITS-1:0] req_packet_handle,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_out_handle,
   output logic [BAND_USED_W-1:0] rsp_band_used,
   output logic                   rsp_head_valid,
   output logic [HANDLE_BITS-1:0] rsp_head_handle,
   output logic [COUNT_W-1:0]     rsp_total_count
);

   localparam int BAND_W    = $clog2(NUM_BANDS);
   localparam int PTR_W     = $clog2(BAND_DEPTH);
   localparam int CNT_W     = $clog2(BAND_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_BANDS * BAND_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int PRIO_N    = 2 ** PRIO_W;

   // config registers
   logic [MAP_W-1:0]   priority_map_ff;
   logic [COUNT_W-1:0] queue_limit_ff;

   // current word
   logic [KIND_W-1:0]      kind_ff;
   logic [PRIO_W-1:0]      prio_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   // band state
   logic [PTR_W-1:0]     head_ptr_ff   [NUM_BANDS];
   logic [PTR_W-1:0]     tail_ptr_ff   [NUM_BANDS];
   logic [CNT_W-1:0]     band_count_ff [NUM_BANDS];
   logic [NUM_BANDS-1:0] nonempty_ff;
   logic [COUNT_W-1:0]   held_ff;

   // operation result before the output register
   status_type             op_status_ff;
   logic [HANDLE_BITS-1:0] op_handle_ff;
   logic [BAND_W-1:0]      op_band_ff;
   logic                   deq_hit_ff;
   logic                   head_valid_ff;

   // output register
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [HANDLE_BITS-1:0] rsp_out_handle_ff;
   logic [BAND_W-1:0]      rsp_band_ff;
   logic                   rsp_head_valid_ff;
   logic [HANDLE_BITS-1:0] rsp_head_handle_ff;
   logic [COUNT_W-1:0]     rsp_total_ff;

   // combinational
   logic [PRIO_W-1:0]      prio_wrap [PRIO_N];
   logic [MAP_ENTRY_W-1:0] map_entry;
   logic [BAND_W-1:0]      map_band;
   logic [BAND_W-1:0]      first_band;
   logic                   any_band;
   logic                   is_enq;
   logic                   is_deq;
   logic [BAND_W-1:0]      op_band;
   logic [CNT_W-1:0]       sel_count;
   logic [PTR_W-1:0]       sel_tail;
   logic [PTR_W-1:0]       sel_head;
   logic                   enq_ok;
   logic                   ram_we;
   logic                   ram_re;
   logic                   addr_tail;
   logic [BAND_W-1:0]      addr_band;
   logic [PTR_W-1:0]       addr_ptr;
   logic [ADDR_W-1:0]      ram_addr;
   logic [HANDLE_BITS-1:0] ram_rdata;
   status_type             exec_status;
   logic [HANDLE_BITS-1:0] exec_handle;
   logic [BAND_W-1:0]      exec_band;
   logic                   exec_deq_hit;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(BAND_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // priority wrap table, built at elaboration
   for (genvar i = 0; i < PRIO_N; i++) begin : g_wrap
      assign prio_wrap[i] = PRIO_W'(i % PRIO_LEVELS);
   end

   // band lookup through the priority map, saturated to the last band
   always_comb begin
      map_entry = priority_map_ff[MAP_ENTRY_W * prio_ff +: MAP_ENTRY_W];
      if (int'(map_entry) >= NUM_BANDS) begin
         map_band = BAND_W'(NUM_BANDS - 1);
      end else begin
         map_band = BAND_W'(map_entry);
      end
   end

   // lowest non-empty band
   always_comb begin
      first_band = '0;
      for (int b = NUM_BANDS - 1; b >= 0; b--) begin
         if (nonempty_ff[b]) begin
            first_band = BAND_W'(b);
         end
      end
   end

   assign any_band  = |nonempty_ff;
   assign is_enq    = (kind_ff == KIND_ENQUEUE);
   assign is_deq    = (kind_ff == KIND_DEQUEUE);
   assign op_band   = is_enq ? map_band : first_band;
   assign sel_count = band_count_ff[op_band];
   assign sel_tail  = tail_ptr_ff[op_band];
   assign sel_head  = head_ptr_ff[first_band];
   assign enq_ok    = (held_ff < queue_limit_ff) && (sel_count < CNT_W'(BAND_DEPTH));

   // band memory port: tail write on enqueue, head read on dequeue and peek
   assign ram_we    = cmd.execute && is_enq && enq_ok;
   assign ram_re    = (cmd.execute && is_deq && any_band) || (cmd.peek && any_band);
   assign addr_tail = cmd.execute && is_enq;
   assign addr_band = addr_tail ? map_band : first_band;
   assign addr_ptr  = addr_tail ? sel_tail : sel_head;
   assign ram_addr  = ADDR_W'(addr_band) * ADDR_W'(BAND_DEPTH) + ADDR_W'(addr_ptr);

   tbpf_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_band_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .read_en    (ram_re),
      .addr       (ram_addr),
      .write_data (handle_ff),
      .read_data  (ram_rdata)
   );

   // result of the operation
   always_comb begin
      exec_status  = STATUS_FLUSHED;
      exec_handle  = '0;
      exec_band    = '0;
      exec_deq_hit = 1'b0;
      case (kind_ff)
         KIND_ENQUEUE: begin
            exec_band = map_band;
            if (enq_ok) begin
               exec_status = STATUS_ENQUEUED;
            end else begin
               exec_status = STATUS_DROPPED;
               exec_handle = handle_ff;
            end
         end
         KIND_DEQUEUE: begin
            if (any_band) begin
               exec_status  = STATUS_DEQUEUED;
               exec_band    = first_band;
               exec_deq_hit = 1'b1;
            end else begin
               exec_status = STATUS_EMPTY;
            end
         end
         default: begin
            exec_status = STATUS_FLUSHED;
         end
      endcase
   end

   // control state: config, band state, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         priority_map_ff <= PRIORITY_MAP_RESET;
         queue_limit_ff  <= QUEUE_LIMIT_RESET;
         nonempty_ff     <= '0;
         held_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int b = 0; b < NUM_BANDS; b++) begin
            head_ptr_ff[b]   <= '0;
            tail_ptr_ff[b]   <= '0;
            band_count_ff[b] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PRIORITY_MAP: priority_map_ff <= csr_write_data;
               CSR_QUEUE_LIMIT:  queue_limit_ff  <= csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end

         if (cmd.execute) begin
            case (kind_ff)
               KIND_ENQUEUE: begin
                  if (enq_ok) begin
                     tail_ptr_ff[map_band]   <= next_ptr(sel_tail);
                     band_count_ff[map_band] <= sel_count + 1'b1;
                     nonempty_ff[map_band]   <= 1'b1;
                     held_ff                 <= held_ff + 1'b1;
                  end
               end
               KIND_DEQUEUE: begin
                  if (any_band) begin
                     head_ptr_ff[first_band]   <= next_ptr(sel_head);
                     band_count_ff[first_band] <= sel_count - 1'b1;
                     if (sel_count == CNT_W'(1)) begin
                        nonempty_ff[first_band] <= 1'b0;
                     end
                     held_ff <= held_ff - 1'b1;
                  end
               end
               default: begin
                  nonempty_ff <= '0;
                  held_ff     <= '0;
                  for (int b = 0; b < NUM_BANDS; b++) begin
                     head_ptr_ff[b]   <= '0;
                     tail_ptr_ff[b]   <= '0;
                     band_count_ff[b] <= '0;
                  end
               end
            endcase
         end

         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind;
         prio_ff   <= prio_wrap[req_priority_req];
         handle_ff <= req_packet_handle;
      end
      if (cmd.execute) begin
         op_status_ff <= exec_status;
         op_handle_ff <= exec_handle;
         op_band_ff   <= exec_band;
         deq_hit_ff   <= exec_deq_hit;
      end
      if (cmd.peek) begin
         if (deq_hit_ff) begin
            op_handle_ff <= ram_rdata;
         end
         head_valid_ff <= any_band;
      end
      if (cmd.publish) begin
         rsp_status_ff      <= op_status_ff;
         rsp_out_handle_ff  <= op_handle_ff;
         rsp_band_ff        <= op_band_ff;
         rsp_head_valid_ff  <= head_valid_ff;
         rsp_head_handle_ff <= head_valid_ff ? ram_rdata : '0;
         rsp_total_ff       <= held_ff;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_handle  = rsp_out_handle_ff;
   assign rsp_band_used   = BAND_USED_W'(rsp_band_ff);
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_head_handle = rsp_head_handle_ff;
   assign rsp_total_count = rsp_total_ff;

endmodule

@@ rtl/three_band_priority_fifo.sv @@
// three_band_priority_fifo: top level of the strict-priority packet queue
// uses tbpf_pkg, tbpf_ctrl and tbpf_datapath (which holds tbpf_ram)
//
// Usage:
//   req channel: one word per operation (enqueue, dequeue, flush; kind 3 also
//   flushes), taken at an edge with req_valid high and req_stall low.
//   rsp channel: exactly one result word per request, in order, taken at an
//   edge with rsp_valid high and rsp_stall low.
//   csr port: write enable, index and data; index 0 is the priority map,
//   index 1 the queue limit. Write only while the queue is idle.
// Sequence:
//   a taken request passes the EXEC, PEEK and LOAD states before its result
//   shows on rsp, and the next request is taken only back in IDLE. The band
//   memory has a single port: EXEC does the tail write or head read, PEEK
//   the head read that gives the peek value, then LOAD does the handoff.
// Reset:
//   all bands become empty and the config registers take their defaults;
//   the band memory keeps its contents and needs no clearing pass.
// Stall:
//   a stalled result holds in the output register; the request in flight
//   finishes and then waits, with req_stall high, until that register frees.
`timescale 1ns / 1ps

module three_band_priority_fifo
   import tbpf_pkg::*;
#(
   parameter int BAND_DEPTH  = BAND_DEPTH_DEF,
   parameter int NUM_BANDS   = NUM_BANDS_DEF,
   parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [PRIO_W-1:0]      req_priority_req,
   input  logic [HANDLE_BITS-1:0] req_packet_handle,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_out_handle,
   output logic [BAND_USED_W-1:0] rsp_band_used,
   output logic                   rsp_head_valid,
   output logic [HANDLE_BITS-1:0] rsp_head_handle,
   output logic [COUNT_W-1:0]     rsp_total_count,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type dp_status;

   // sequencer
   tbpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // queue state and result register
   tbpf_datapath #(
      .BAND_DEPTH  (BAND_DEPTH),
      .NUM_BANDS   (NUM_BANDS),
      .PRIO_LEVELS (PRIO_LEVELS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .dp_status         (dp_status),
      .req_kind          (req_kind),
      .req_priority_req  (req_priority_req),
      .req_packet_handle (req_packet_handle),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_band_used     (rsp_band_used),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_handle   (rsp_head_handle),
      .rsp_total_count   (rsp_total_count)
   );

   // one operation in flight: a taken word closes the request side next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another operation is in flight");

   // peek value is zero when no band holds a packet
   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_head_handle == '0)
      else $error("head handle nonzero with no packet held");

   // flush leaves every band empty
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FLUSHED |->
         rsp_total_count == '0 && !rsp_head_valid)
      else $error("flush result shows packets held");

   // empty dequeue only when nothing is held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |->
         rsp_total_count == '0 && !rsp_head_valid && rsp_out_handle == '0)
      else $error("empty dequeue with packets held");

endmodule

@@ tb/three_band_priority_fifo_test.sv @@
// three_band_priority_fifo_test: self-checking bench for the three-band priority fifo;
// directed and random queue operations are checked against a built-in queue predictor
// depends on tbpf_pkg and three_band_priority_fifo
`timescale 1ns / 1ps

module three_band_priority_fifo_test
   import tbpf_pkg::*;
();

   localparam int HANDLE_W    = HANDLE_BITS_DEF;
   localparam int NUM_BANDS   = NUM_BANDS_DEF;
   localparam int BAND_DEPTH  = BAND_DEPTH_DEF;
   localparam int PRIO_LEVELS = PRIO_LEVELS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   // unused operation code, behaves as a flush
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct {
      status_type             status;
      logic [HANDLE_W-1:0]    out_handle;
      logic [BAND_USED_W-1:0] band_used;
      logic                   head_valid;
      logic [HANDLE_W-1:0]    head_handle;
      logic [COUNT_W-1:0]     total_count;
   } queue_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [KIND_W-1:0]      req_kind = '0;
   logic [PRIO_W-1:0]      req_priority_req = '0;
   logic [HANDLE_W-1:0]    req_packet_handle = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [HANDLE_W-1:0]    rsp_out_handle;
   logic [BAND_USED_W-1:0] rsp_band_used;
   logic                   rsp_head_valid;
   logic [HANDLE_W-1:0]    rsp_head_handle;
   logic [COUNT_W-1:0]     rsp_total_count;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // predictor state: bands, pointers, fill levels and registers
   logic [HANDLE_W-1:0] band_mem [NUM_BANDS][BAND_DEPTH];
   int                  head_ptr [NUM_BANDS];
   int                  tail_ptr [NUM_BANDS];
   int                  band_fill [NUM_BANDS];
   int                  packets_held;
   logic [MAP_W-1:0]    prio_map;
   logic [COUNT_W-1:0]  queue_limit;

   queue_result_type expected_words[$];
   int               error_count = 0;
   int               result_index = 0;
   int               cycle_count = 0;

   // sender and receiver pacing
   int max_gap = 4;
   int burst_left = 0;
   int stall_pct = 25;
   int hold_request = 0;
   int hold_left = 0;

   three_band_priority_fifo i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_priority_req  (req_priority_req),
      .req_packet_handle (req_packet_handle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_handle    (rsp_out_handle),
      .rsp_band_used     (rsp_band_used),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_handle   (rsp_head_handle),
      .rsp_total_count   (rsp_total_count),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got 0x%0h want 0x%0h",
                                   result_index, name, got, want));
   endtask

   // ---------------- queue predictor ----------------

   task automatic reset_queue_model();
      for (int b = 0; b < NUM_BANDS; b++) begin
         head_ptr[b] = 0;
         tail_ptr[b] = 0;
         band_fill[b] = 0;
      end
      packets_held = 0;
      prio_map = PRIORITY_MAP_RESET;
      queue_limit = QUEUE_LIMIT_RESET;
   endtask

   function automatic int next_slot(input int p);
      return (p + 1 >= BAND_DEPTH) ? 0 : p + 1;
   endfunction

   // lowest band holding a packet, NUM_BANDS when all are empty
   function automatic int lowest_busy_band();
      for (int b = 0; b < NUM_BANDS; b++)
         if (band_fill[b] != 0)
            return b;
      return NUM_BANDS;
   endfunction

   function automatic queue_result_type apply_queue_op(input logic [KIND_W-1:0] kind,
                                                       input logic [PRIO_W-1:0] prio,
                                                       input logic [HANDLE_W-1:0] handle);
      queue_result_type res;
      int band;
      int head_band;
      res.status = STATUS_FLUSHED;
      res.out_handle = '0;
      res.head_handle = '0;
      band = 0;
      case (kind)
         KIND_ENQUEUE: begin
            // map entry picks the band, saturating at the last band
            band = int'(prio_map[2 * (prio % PRIO_LEVELS) +: MAP_ENTRY_W]);
            if (band >= NUM_BANDS)
               band = NUM_BANDS - 1;
            if (packets_held < queue_limit && band_fill[band] < BAND_DEPTH) begin
               band_mem[band][tail_ptr[band]] = handle;
               tail_ptr[band] = next_slot(tail_ptr[band]);
               band_fill[band]++;
               packets_held++;
               res.status = STATUS_ENQUEUED;
            end else begin
               res.status = STATUS_DROPPED;
               res.out_handle = handle;
            end
         end
         KIND_DEQUEUE: begin
            band = lowest_busy_band();
            if (band < NUM_BANDS) begin
               res.out_handle = band_mem[band][head_ptr[band]];
               head_ptr[band] = next_slot(head_ptr[band]);
               band_fill[band]--;
               packets_held--;
               res.status = STATUS_DEQUEUED;
            end else begin
               band = 0;
               res.status = STATUS_EMPTY;
            end
         end
         default: begin
            // flush, also taken by the spare code
            for (int b = 0; b < NUM_BANDS; b++) begin
               head_ptr[b] = 0;
               tail_ptr[b] = 0;
               band_fill[b] = 0;
            end
            packets_held = 0;
            res.status = STATUS_FLUSHED;
         end
      endcase
      // peek value after the operation
      head_band = lowest_busy_band();
      res.head_valid = (head_band < NUM_BANDS);
      if (head_band < NUM_BANDS)
         res.head_handle = band_mem[head_band][head_ptr[head_band]];
      res.band_used = BAND_USED_W'(band);
      res.total_count = COUNT_W'(packets_held);
      return res;
   endfunction

   // ---------------- channel drivers ----------------

   // offer one word in bursts with random gaps, predict it once taken
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PRIO_W-1:0] prio,
                            input logic [HANDLE_W-1:0] handle);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (max_gap == 0) ? 0 : $urandom_range(max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_priority_req <= prio;
      req_packet_handle <= handle;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(apply_queue_op(kind, prio, handle));
   endtask

   task automatic send_random_op(input int enq_pct, input int deq_pct);
      int pick;
      logic [KIND_W-1:0] kind;
      pick = $urandom_range(99);
      if (pick < enq_pct)
         kind = KIND_ENQUEUE;
      else if (pick < enq_pct + deq_pct)
         kind = KIND_DEQUEUE;
      else
         kind = $urandom_range(1) ? KIND_FLUSH : KIND_SPARE;
      send_word(kind, PRIO_W'($urandom_range(15)), HANDLE_W'($urandom));
   endtask

   // sender pauses until every expected word has come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_PRIORITY_MAP)
         prio_map = data;
      else
         queue_limit = data[COUNT_W-1:0];
      @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing expected",
                                      result_index));
         end else begin
            want = expected_words.pop_front();
            check_field("status", 32'(rsp_status), 32'(want.status));
            check_field("out_handle", 32'(rsp_out_handle), 32'(want.out_handle));
            check_field("band_used", 32'(rsp_band_used), 32'(want.band_used));
            check_field("head_valid", 32'(rsp_head_valid), 32'(want.head_valid));
            check_field("head_handle", 32'(rsp_head_handle), 32'(want.head_handle));
            check_field("total_count", 32'(rsp_total_count), 32'(want.total_count));
         end
         result_index++;
      end
   end

   // ---------------- tests ----------------

   // reset map and limit: every priority, strict order, both flush codes
   task automatic test_reset_defaults();
      send_word(KIND_DEQUEUE, 4'hF, 16'hFFFF);
      for (int p = 0; p < PRIO_LEVELS; p++) begin
         if (p == 0)
            send_word(KIND_ENQUEUE, PRIO_W'(p), 16'h0000);
         else if (p == PRIO_LEVELS - 1)
            send_word(KIND_ENQUEUE, PRIO_W'(p), 16'hFFFF);
         else
            send_word(KIND_ENQUEUE, PRIO_W'(p), HANDLE_W'($urandom));
      end
      send_word(KIND_DEQUEUE, 4'h0, 16'h0000);
      send_word(KIND_DEQUEUE, 4'h0, 16'h0000);
      send_word(KIND_SPARE, 4'h0, 16'h0000);
      send_word(KIND_DEQUEUE, 4'h0, 16'h0000);
      send_word(KIND_ENQUEUE, 4'h6, 16'h8001);
      send_word(KIND_FLUSH, 4'hF, 16'hFFFF);
   endtask

   // zero limit with junk in the upper data bits, saturated map, tiny limit
   task automatic test_limit_and_map_extremes();
      wait_until_drained();
      write_register(CSR_PRIORITY_MAP, 32'hFFFF_FFFF);
      write_register(CSR_QUEUE_LIMIT, 32'hFFFF_F800);
      send_word(KIND_ENQUEUE, 4'h9, 16'h1234);
      wait_until_drained();
      write_register(CSR_PRIORITY_MAP, 32'h0000_0000);
      write_register(CSR_QUEUE_LIMIT, 32'd2);
      send_word(KIND_ENQUEUE, 4'h3, 16'hA5A5);
      send_word(KIND_ENQUEUE, 4'hC, 16'h5A5A);
      send_word(KIND_ENQUEUE, 4'h7, 16'h0F0F);
      send_word(KIND_DEQUEUE, 4'h0, 16'h0000);
   endtask

   // limit above range: one band fills completely, then drops on a full band
   task automatic test_band_overflow();
      wait_until_drained();
      stall_pct = 30;
      max_gap = 3;
      write_register(CSR_QUEUE_LIMIT, $urandom | 32'h0000_07FF);
      write_register(CSR_PRIORITY_MAP, 32'hAAAA_AAAA | ($urandom & 32'h5555_5555));
      while (band_fill[NUM_BANDS-1] < BAND_DEPTH)
         send_word(KIND_ENQUEUE, PRIO_W'($urandom_range(15)), HANDLE_W'($urandom));
      repeat (3)
         send_word(KIND_ENQUEUE, PRIO_W'($urandom_range(15)), HANDLE_W'($urandom));
      // limit at the band depth, queue held at or above it
      wait_until_drained();
      write_register(CSR_QUEUE_LIMIT, 32'd1024);
      send_word(KIND_ENQUEUE, 4'h2, 16'hFFFF);
      send_word(KIND_DEQUEUE, 4'h0, 16'h0000);
      send_word(KIND_ENQUEUE, 4'h5, 16'h0001);
      send_word(KIND_DEQUEUE, 4'h0, 16'h0000);
      send_word(KIND_ENQUEUE, 4'hE, 16'h7FFE);
      wait_until_drained();
      write_register(CSR_PRIORITY_MAP, $urandom);
      repeat (20) send_random_op(45, 52);
      send_word(KIND_FLUSH, 4'h0, 16'h0000);
   endtask

   // several register settings with random pacing, one stretch with none
   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         wait_until_drained();
         case (phase)
            0: begin
               write_register(CSR_PRIORITY_MAP, 32'h0000_0000);
               write_register(CSR_QUEUE_LIMIT, 32'd1024);
               stall_pct = 0;
               max_gap = 0;
            end
            1: begin
               write_register(CSR_PRIORITY_MAP, 32'hFFFF_FFFF);
               write_register(CSR_QUEUE_LIMIT, 32'd1);
               stall_pct = 50;
               max_gap = 2;
            end
            default: begin
               write_register(CSR_PRIORITY_MAP, $urandom);
               write_register(CSR_QUEUE_LIMIT,
                              phase[0] ? 32'd1024 : 32'($urandom_range(24)));
               stall_pct = $urandom_range(70);
               max_gap = $urandom_range(6);
            end
         endcase
         repeat (10) send_random_op(55, 40);
      end
   endtask

   // long receiver hold-off while the sender keeps offering, then a full drain and more random traffic
   task automatic test_long_backpressure();
      wait_until_drained();
      write_register(CSR_QUEUE_LIMIT, 32'd1000);
      stall_pct = 0;
      max_gap = 0;
      hold_request = 80;
      repeat (30) send_random_op(60, 35);
      wait_until_drained();
      stall_pct = 40;
      max_gap = 5;
      repeat (10) send_random_op(50, 45);
   endtask

   initial begin
      reset_queue_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_limit_and_map_extremes();
      test_band_overflow();
      test_random_settings();
      test_long_backpressure();
      wait_until_drained();
      repeat (8) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ three_band_priority_fifo.f @@
rtl/tbpf_pkg.sv
rtl/tbpf_ram.sv
rtl/tbpf_ctrl.sv
rtl/tbpf_datapath.sv
rtl/three_band_priority_fifo.sv
tb/three_band_priority_fifo_test.sv
